FILE: rtl/ira_pkg.sv
// Package for the interval room allocator.
// Holds field widths, parameter defaults, status codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ira_pkg;

   localparam int CLIENT_ID_W    = 10;
   localparam int RESOURCE_W     = 11;
   localparam int STATUS_W       = 2;

   localparam int MAX_CLIENTS_DEF   = 1024;
   localparam int MAX_RESOURCES_DEF = 1024;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 2'd0,
      ST_NO_RESOURCE   = 2'd1,
      ST_NO_ASSIGNMENT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // event kind on req_type
   localparam logic EV_ARRIVAL   = 1'b0;
   localparam logic EV_DEPARTURE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/interval_room_allocator.sv
// Interval room allocator top level: free-stack and assignment-table memories with
// a read / modify / write controller. Depends on ira_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes time-ordered arrival and departure items, one result item per request item.
// An arrival pops the most recently freed resource off a LIFO free stack, or opens a
// new resource numbered from 1 when the stack is empty; a departure pushes the
// client's resource back and clears its record. After reset the assignment table is
// cleared one entry per cycle, and req_stall stays high until every entry is cleared.
// Each item then reads the table and the top of the stack from their synchronous
// memories in FSM_IDLE, and updates them and loads the result register in FSM_EXEC.
// Only one item is in the read/modify/write path at a time. A waiting result does not
// block the next item's read; the update waits until the result is taken.
module interval_room_allocator
   import ira_pkg::*;
#(
   parameter int MAX_CLIENTS   = MAX_CLIENTS_DEF,
   parameter int MAX_RESOURCES = MAX_RESOURCES_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire                    req_type,
   input  wire [CLIENT_ID_W-1:0]  req_client_id,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [RESOURCE_W-1:0]  rsp_resource_num,
   output logic [RESOURCE_W-1:0]  rsp_resources_opened,
   output logic [STATUS_W-1:0]    rsp_status
);

   localparam int CLI_AW = $clog2(MAX_CLIENTS);
   localparam int SA_W   = $clog2(MAX_RESOURCES);
   localparam int RES_W  = $clog2(MAX_RESOURCES + 1);

   // memories
   logic [RES_W-1:0] tbl_mem [MAX_CLIENTS];
   logic [RES_W-1:0] stk_mem [MAX_RESOURCES];

   logic              tbl_we, tbl_re;
   logic [CLI_AW-1:0] tbl_waddr, tbl_raddr;
   logic [RES_W-1:0]  tbl_wdata, tbl_rd_ff;
   logic              stk_we, stk_re;
   logic [SA_W-1:0]   stk_waddr, stk_raddr;
   logic [RES_W-1:0]  stk_wdata, stk_rd_ff;

   // control and state
   fsm_type           state_ff, state_in;
   logic [CLI_AW-1:0] clr_ff, clr_in;
   logic [RES_W-1:0]  fc_ff, fc_in;
   logic [RES_W-1:0]  opened_ff, opened_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // captured request
   logic              is_dep_ff;
   logic [CLI_AW-1:0] cid_ff;
   logic              in_rng_ff;

   // result register
   logic [RES_W-1:0]  rsp_res_ff, rsp_res_in;
   logic [RES_W-1:0]  rsp_opened_ff, rsp_opened_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [31:0]       cid_ext;
   logic              req_in_rng;
   logic [RES_W-1:0]  fc_dec;
   logic              accept;

   assign cid_ext    = 32'(req_client_id);
   assign req_in_rng = (cid_ext < 32'(MAX_CLIENTS));
   assign fc_dec     = fc_ff - RES_W'(1);
   assign accept     = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         fc_ff        <= '0;
         opened_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fc_ff        <= fc_in;
         opened_ff    <= opened_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_dep_ff <= req_type;
         cid_ff    <= cid_ext[CLI_AW-1:0];
         in_rng_ff <= req_in_rng;
      end
      rsp_res_ff    <= rsp_res_in;
      rsp_opened_ff <= rsp_opened_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      fc_in         = fc_ff;
      opened_in     = opened_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_res_in    = rsp_res_ff;
      rsp_opened_in = rsp_opened_ff;
      rsp_status_in = rsp_status_ff;
      req_stall     = 1'b1;
      tbl_we        = 1'b0;
      tbl_waddr     = cid_ff;
      tbl_wdata     = '0;
      tbl_re        = 1'b0;
      tbl_raddr     = cid_ext[CLI_AW-1:0];
      stk_we        = 1'b0;
      stk_waddr     = fc_ff[SA_W-1:0];
      stk_wdata     = tbl_rd_ff;
      stk_re        = 1'b0;
      stk_raddr     = fc_dec[SA_W-1:0];

      case (state_ff)
         FSM_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            clr_in    = clr_ff + CLI_AW'(1);
            if (clr_ff == CLI_AW'(MAX_CLIENTS - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               tbl_re   = 1'b1;
               stk_re   = 1'b1;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            // commit only once the result register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_res_in    = '0;
               rsp_status_in = ST_OK;
               state_in      = FSM_IDLE;
               if (!in_rng_ff) begin
                  rsp_status_in = is_dep_ff ? ST_NO_ASSIGNMENT : ST_NO_RESOURCE;
               end else if (is_dep_ff == EV_ARRIVAL) begin
                  if (fc_ff != '0) begin
                     fc_in      = fc_dec;
                     rsp_res_in = stk_rd_ff;
                     tbl_we     = 1'b1;
                     tbl_wdata  = stk_rd_ff;
                  end else if (opened_ff < RES_W'(MAX_RESOURCES)) begin
                     opened_in  = opened_ff + RES_W'(1);
                     rsp_res_in = opened_ff + RES_W'(1);
                     tbl_we     = 1'b1;
                     tbl_wdata  = opened_ff + RES_W'(1);
                  end else begin
                     rsp_status_in = ST_NO_RESOURCE;
                  end
               end else begin
                  rsp_res_in = tbl_rd_ff;
                  if (tbl_rd_ff == '0) begin
                     rsp_status_in = ST_NO_ASSIGNMENT;
                  end else begin
                     // push dropped if the stack is somehow full
                     if (fc_ff < RES_W'(MAX_RESOURCES)) begin
                        stk_we = 1'b1;
                        fc_in  = fc_ff + RES_W'(1);
                     end
                     tbl_we    = 1'b1;
                     tbl_wdata = '0;
                  end
               end
               rsp_opened_in = opened_in;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_resource_num     = RESOURCE_W'(rsp_res_ff);
   assign rsp_resources_opened = RESOURCE_W'(rsp_opened_ff);
   assign rsp_status           = rsp_status_ff;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for interval_room_allocator (ports and codes from ira_pkg).
// Plain tasks drive arrival/departure items; a small scoreboard class predicts each result.

module tb_top;
   import ira_pkg::*;

   localparam int MAX_ROOMS   = MAX_RESOURCES_DEF;
   localparam int NUM_CLIENTS = MAX_CLIENTS_DEF;
   localparam int SEND_IDLE_PCT [4] = '{0, 65, 0, 33};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 65, 33};
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [RESOURCE_W-1:0] room;
      logic [RESOURCE_W-1:0] opened;
      status_type            status;
   } outcome_type;

   class room_ledger;
      logic [RESOURCE_W-1:0] free_rooms[MAX_ROOMS];
      logic [RESOURCE_W-1:0] room_of[NUM_CLIENTS];
      int unsigned free_count;
      int unsigned opened_count;
      int unsigned present[$];   // clients holding a room right now
      outcome_type awaited[$];
      int unsigned errors, checked, refused, orphans;

      function new();
         foreach (free_rooms[i]) free_rooms[i] = '0;
         foreach (room_of[i]) room_of[i] = '0;
         free_count   = 0;
         opened_count = 0;
         errors       = 0;
         checked      = 0;
         refused      = 0;
         orphans      = 0;
      endfunction

      task report(string msg);
         if (errors < PRINT_CAP)
            $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      function void drop_present(int unsigned cid);
         for (int i = 0; i < present.size(); i++) begin
            if (present[i] == cid) begin
               present.delete(i);
               break;
            end
         end
      endfunction

      function void note_event(logic kind, logic [CLIENT_ID_W-1:0] cid);
         outcome_type o;
         o.room   = '0;
         o.opened = '0;
         o.status = ST_OK;
         if (kind == EV_ARRIVAL) begin
            if (free_count > 0) begin
               free_count--;
               o.room = free_rooms[free_count];
            end else if (opened_count < MAX_ROOMS) begin
               opened_count++;
               o.room = RESOURCE_W'(opened_count);
            end else begin
               o.status = ST_NO_RESOURCE;
               refused++;
            end
            if (o.status == ST_OK) begin
               // re-arrival overwrites the record, the old room is lost
               if (room_of[cid] == '0)
                  present.insert(present.size(), 32'(cid));
               room_of[cid] = o.room;
            end
         end else begin
            o.room = room_of[cid];
            if (o.room == '0) begin
               o.status = ST_NO_ASSIGNMENT;
               orphans++;
            end else begin
               if (free_count < MAX_ROOMS) begin
                  free_rooms[free_count] = o.room;
                  free_count++;
               end
               room_of[cid] = '0;
               drop_present(cid);
            end
         end
         o.opened = RESOURCE_W'(opened_count);
         awaited.insert(awaited.size(), o);
      endfunction

      task check_result(logic [RESOURCE_W-1:0] room, logic [RESOURCE_W-1:0] opened,
                        logic [STATUS_W-1:0] status);
         outcome_type o;
         if (awaited.size() == 0) begin
            report($sformatf("result with none pending: room %0d opened %0d status %0d",
                             room, opened, status));
            return;
         end
         o = awaited.pop_front();
         checked++;
         if (room !== o.room)
            report($sformatf("item %0d resource_num %0d, predicted %0d", checked, room, o.room));
         if (opened !== o.opened)
            report($sformatf("item %0d resources_opened %0d, predicted %0d",
                             checked, opened, o.opened));
         if (status !== o.status)
            report($sformatf("item %0d status %0d, predicted %0d", checked, status, o.status));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_type;
   logic [CLIENT_ID_W-1:0] req_client_id;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [RESOURCE_W-1:0]  rsp_resource_num;
   logic [RESOURCE_W-1:0]  rsp_resources_opened;
   logic [STATUS_W-1:0]    rsp_status;

   room_ledger  ledger;
   int unsigned sent;
   int unsigned stall_pct;

   interval_room_allocator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_client_id       (req_client_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_resource_num    (rsp_resource_num),
      .rsp_resources_opened(rsp_resources_opened),
      .rsp_status          (rsp_status)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_result(rsp_resource_num, rsp_resources_opened, rsp_status);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // idling mode rotates every 100 items; the first mixed run and the room fill see every mode
   task automatic send_item(logic kind, logic [CLIENT_ID_W-1:0] cid);
      int unsigned mode;
      mode      = (sent / 100) % 4;
      stall_pct = RECV_STALL_PCT[mode];
      while ($urandom_range(99) < SEND_IDLE_PCT[mode]) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_client_id <= cid;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ledger.note_event(kind, cid);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0)
         @(posedge clock);
   endtask

   // mostly well-formed arrivals and departures, some stray departures and re-arrivals
   task automatic mixed_traffic(int unsigned n);
      int unsigned r, p, tries;
      logic [CLIENT_ID_W-1:0] cid;
      logic kind;
      repeat (n) begin
         r     = $urandom_range(99);
         p     = ledger.present.size();
         kind  = EV_ARRIVAL;
         cid   = CLIENT_ID_W'($urandom_range(NUM_CLIENTS - 1));
         tries = 0;
         if (r < 10) begin
            kind = EV_DEPARTURE;
         end else if (r < 18 && p > 0) begin
            cid = CLIENT_ID_W'(ledger.present[$urandom_range(p - 1)]);
         end else if (r < 21) begin
            kind = ($urandom_range(1) == 0) ? EV_ARRIVAL : EV_DEPARTURE;
         end else if (p > 0 && $urandom_range(99) >= ((p < 24) ? 65 : 40)) begin
            kind = EV_DEPARTURE;
            cid  = CLIENT_ID_W'(ledger.present[$urandom_range(p - 1)]);
         end else begin
            while (ledger.room_of[cid] != '0 && tries < 32) begin
               cid = CLIENT_ID_W'($urandom_range(NUM_CLIENTS - 1));
               tries++;
            end
         end
         send_item(kind, cid);
      end
   endtask

   // arrivals until every room is open and none is free, then a few refused ones
   task automatic fill_rooms();
      while (!(ledger.opened_count == MAX_ROOMS && ledger.free_count == 0))
         send_item(EV_ARRIVAL, CLIENT_ID_W'($urandom_range(NUM_CLIENTS - 1)));
      repeat (6)
         send_item(EV_ARRIVAL, CLIENT_ID_W'($urandom_range(NUM_CLIENTS - 1)));
   endtask

   initial begin
      ledger        = new();
      sent          = 0;
      stall_pct     = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = EV_ARRIVAL;
      req_client_id = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes of client_id, LIFO order, stray departure, overwrite on re-arrival
      send_item(EV_ARRIVAL,   10'd0);
      send_item(EV_ARRIVAL,   10'd1023);
      send_item(EV_DEPARTURE, 10'd1023);
      send_item(EV_DEPARTURE, 10'd1023);
      send_item(EV_ARRIVAL,   10'd5);
      send_item(EV_DEPARTURE, 10'd0);
      send_item(EV_DEPARTURE, 10'd5);
      send_item(EV_ARRIVAL,   10'd7);
      send_item(EV_ARRIVAL,   10'd8);
      send_item(EV_ARRIVAL,   10'd7);
      send_item(EV_DEPARTURE, 10'd7);
      send_item(EV_DEPARTURE, 10'd8);
      send_item(EV_DEPARTURE, 10'd512);
      send_item(EV_ARRIVAL,   10'd1023);
      send_item(EV_ARRIVAL,   10'd682);
      send_item(EV_DEPARTURE, 10'd341);
      drain();

      mixed_traffic(300);
      fill_rooms();
      drain();
      mixed_traffic(250);
      drain();
      repeat (16) @(posedge clock);

      $display("Covered %0d items, %0d results checked; %0d rooms opened, %0d arrivals refused.",
               sent, ledger.checked, ledger.opened_count, ledger.refused);
      $display("%0d departures found no room on record; %0d rooms left on the free stack.",
               ledger.orphans, ledger.free_count);
      if (ledger.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: run did not complete");
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ira_pkg.sv
rtl/interval_room_allocator.sv
sim/tb_top.sv
